// File: rtl/empirical_p_value_lookup_core_assert.svh
// assertion macros for the p-value lookup core
`ifndef EMPIRICAL_P_VALUE_LOOKUP_CORE_ASSERT_SVH
`define EMPIRICAL_P_VALUE_LOOKUP_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

`define EPVL_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define EPVL_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`define EPVL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define EPVL_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define EPVL_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define EPVL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/epvl_pkg.sv
// types and constants for the p-value lookup core
package epvl_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int LEN_W       = ADDR_W + 1;
	localparam int SCORE_W     = 32;
	localparam int TOTAL_W     = 24;
	localparam int FRAC_W      = 17;
	localparam int DEN_W       = TOTAL_W + FRAC_W;
	localparam int P_W         = 17;
	localparam int NUM_W       = LEN_W + 32;
	localparam int DSH_W       = DEN_W + 16;
	localparam int CNT_W       = 5;

	localparam logic [P_W-1:0]     ONE_Q16        = P_W'(65536);
	localparam logic [TOTAL_W-1:0] TOTAL_RESET    = TOTAL_W'(1);
	localparam logic [FRAC_W-1:0]  FRACTION_RESET = FRAC_W'(65536);
	localparam logic [LEN_W-1:0]   LENGTH_RESET   = LEN_W'(TABLE_DEPTH);
	localparam logic [LEN_W-1:0]   LENGTH_MIN     = LEN_W'(2);
	localparam logic [LEN_W-1:0]   LENGTH_MAX     = LEN_W'(TABLE_DEPTH);

	localparam logic [1:0] REG_TOTAL    = 2'd0;
	localparam logic [1:0] REG_FRACTION = 2'd1;
	localparam logic [1:0] REG_LENGTH   = 2'd2;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_FIRST,
		ST_RD_SECOND,
		ST_RD_LAST,
		ST_CHECK,
		ST_SCAN,
		ST_DIV_SETUP,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

// File: rtl/empirical_p_value_lookup_core.sv
// p-value lookup core: reference table, linear rank search and serial divider
//
//   channel   kind        word
//   s_*       stream in   load (tuser 0) or query (tuser 1) word
//   m_*       stream out  one result word per query
//   p*        apb         total_count, fraction_q16, table_length
//
// a load leaves s_tready high; a query holds it low through three table reads, a
// range check, one scan read per entry up to the first one passed or the last one,
// a divide setup step, 17 restoring divider steps and a result step; a query beyond
// the table skips scan and divide, a saturated one skips the divide; a finished
// result waits in the output register; a second one waiting on m_tready holds the
// block in its result step; reset clears control and configuration only
module empirical_p_value_lookup_core import epvl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // entry_index[11:0], score_value[43:12], zero pad
	input  logic [0:0]  s_tuser,   // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // p_value_q16[16:0], rank_position[29:17],
	                               // beyond_table[30], significant[31]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	state_t state_q, state_d;

	logic [TOTAL_W-1:0] total_q;
	logic [FRAC_W-1:0]  fraction_q;
	logic [LEN_W-1:0]   tlen_q;

	logic                      accept;
	logic                      s_cmd;
	logic [ADDR_W-1:0]         s_idx;
	logic signed [SCORE_W-1:0] s_score;
	logic                      cfg_wr;

	logic signed [SCORE_W-1:0] table_mem [TABLE_DEPTH];
	logic signed [SCORE_W-1:0] rdata_q;
	logic [ADDR_W-1:0]         raddr;

	logic signed [SCORE_W-1:0] query_q;
	logic signed [SCORE_W-1:0] first_q;
	logic [LEN_W-1:0]          len_q;
	logic [ADDR_W-1:0]         last_q;
	logic                      desc_q;
	logic [LEN_W-1:0]          idx_q;
	logic [DEN_W-1:0]          den_q;
	logic [NUM_W-1:0]          rem_q;
	logic [DSH_W-1:0]          dsh_q;
	logic [P_W-1:0]            quo_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [P_W-1:0]            p_q;
	logic                      sig_q;
	logic                      beyond_q;

	logic                      out_valid_q;
	logic [P_W-1:0]            out_p_q;
	logic [LEN_W-1:0]          out_rank_q;
	logic                      out_beyond_q;
	logic                      out_sig_q;

	logic [LEN_W-1:0]          len_clamp;
	logic                      beyond_now;
	logic                      passes;
	logic [LEN_W-1:0]          rank;
	logic                      den_zero;
	logic                      div_sat;
	logic                      sig_now;
	logic                      rem_ge;
	logic [P_W-1:0]            quo_next;
	logic                      out_load;

	assign s_cmd   = s_tuser[0];
	assign s_idx   = s_tdata[ADDR_W-1:0];
	assign s_score = s_tdata[ADDR_W+SCORE_W-1:ADDR_W];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= TOTAL_RESET;
			fraction_q <= FRACTION_RESET;
			tlen_q     <= LENGTH_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_TOTAL:    total_q    <= pwdata[TOTAL_W-1:0];
				REG_FRACTION: fraction_q <= pwdata[FRAC_W-1:0];
				REG_LENGTH:   tlen_q     <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_TOTAL:    prdata = 32'(total_q);
			REG_FRACTION: prdata = 32'(fraction_q);
			REG_LENGTH:   prdata = 32'(tlen_q);
			default:      prdata = '0;
		endcase
	end

	// table memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (accept && s_cmd == CMD_LOAD) begin
			table_mem[s_idx] <= s_score;
		end
		rdata_q <= table_mem[raddr];
	end

	// compare and divide logic
	assign len_clamp  = (tlen_q < LENGTH_MIN) ? LENGTH_MIN :
	                    (tlen_q > LENGTH_MAX) ? LENGTH_MAX : tlen_q;
	assign beyond_now = desc_q ? (query_q < rdata_q) : (query_q > rdata_q);
	assign passes     = desc_q ? (query_q > rdata_q) : (query_q < rdata_q);
	assign rank       = idx_q + LEN_W'(1);
	assign den_zero   = (den_q == '0);
	assign div_sat    = (DEN_W'({rank, 15'b0}) >= den_q);
	assign sig_now    = (DEN_W'({rank, 16'b0}) < den_q);
	assign rem_ge     = (DSH_W'(rem_q) >= dsh_q);
	assign quo_next   = {quo_q[P_W-2:0], rem_ge};
	assign out_load   = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		raddr   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && s_cmd == CMD_QUERY) begin
					state_d = ST_RD_FIRST;
				end
			end
			ST_RD_FIRST: begin
				raddr   = '0;
				state_d = ST_RD_SECOND;
			end
			ST_RD_SECOND: begin
				raddr   = ADDR_W'(1);
				state_d = ST_RD_LAST;
			end
			ST_RD_LAST: begin
				raddr   = last_q;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				raddr   = '0;
				state_d = beyond_now ? ST_DONE : ST_SCAN;
			end
			ST_SCAN: begin
				raddr = idx_q[ADDR_W-1:0] + ADDR_W'(1);
				if (passes || idx_q[ADDR_W-1:0] == last_q) begin
					state_d = ST_DIV_SETUP;
				end
			end
			ST_DIV_SETUP: begin
				state_d = (den_zero || div_sat) ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept && s_cmd == CMD_QUERY) begin
					query_q <= s_score;
					len_q   <= len_clamp;
					last_q  <= ADDR_W'(len_clamp - LEN_W'(1));
				end
			end
			ST_RD_FIRST: begin
				den_q <= DEN_W'(total_q) * DEN_W'(fraction_q);
			end
			ST_RD_SECOND: begin
				first_q <= rdata_q;
			end
			ST_RD_LAST: begin
				desc_q <= (first_q > rdata_q);
			end
			ST_CHECK: begin
				if (beyond_now) begin
					idx_q    <= len_q;
					p_q      <= ONE_Q16;
					sig_q    <= 1'b0;
					beyond_q <= 1'b1;
				end else begin
					idx_q    <= '0;
					beyond_q <= 1'b0;
				end
			end
			ST_SCAN: begin
				if (!passes) begin
					idx_q <= idx_q + LEN_W'(1);
				end
			end
			ST_DIV_SETUP: begin
				if (den_zero || div_sat) begin
					p_q   <= ONE_Q16;
					sig_q <= 1'b0;
				end else begin
					sig_q <= sig_now;
					rem_q <= {rank, 32'b0};
					dsh_q <= {den_q, 16'b0};
					quo_q <= '0;
					cnt_q <= CNT_W'(P_W - 1);
				end
			end
			ST_DIV: begin
				if (rem_ge) begin
					rem_q <= rem_q - dsh_q[NUM_W-1:0];
				end
				quo_q <= quo_next;
				dsh_q <= dsh_q >> 1;
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					p_q <= (quo_next > ONE_Q16) ? ONE_Q16 : quo_next;
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_p_q      <= p_q;
			out_rank_q   <= rank;
			out_beyond_q <= beyond_q;
			out_sig_q    <= sig_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_sig_q, out_beyond_q, out_rank_q, out_p_q};

	`include "empirical_p_value_lookup_core_assert.svh"

	`EPVL_ASSERT_IMPLY(a_beyond_sat, clk, arst_n, out_valid_q && out_beyond_q, out_p_q == ONE_Q16 && !out_sig_q, "beyond result not saturated")
	`EPVL_ASSERT_IMPLY(a_sig_below_one, clk, arst_n, out_valid_q && out_sig_q, out_p_q < ONE_Q16, "significant result with p at one")
	`EPVL_ASSERT_IMPLY(a_scan_bound, clk, arst_n, state_q == ST_SCAN, idx_q <= LEN_W'(last_q), "scan ran past last entry")
	`EPVL_ASSERT_NEXT(a_query_start, clk, arst_n, accept && s_cmd == CMD_QUERY, state_q == ST_RD_FIRST && !s_tready, "query word did not start a search")

endmodule

// File: tb/epvl_checker.sv
`timescale 1ns / 1ps
// checker for the p-value lookup core: watches all channels, predicts each query and compares
module epvl_checker import epvl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,   // entry_index[11:0], score_value[43:12], zero pad
	input  logic [0:0]  s_tuser,   // command
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // p_value_q16[16:0], rank_position[29:17],
	                               // beyond_table[30], significant[31]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	output int          pending,
	output int          fails
);

	typedef struct packed {
		logic [P_W-1:0]   p_value;
		logic [LEN_W-1:0] rank;
		logic             beyond;
		logic             significant;
	} result_t;

	logic signed [SCORE_W-1:0] scores [TABLE_DEPTH];
	logic [TOTAL_W-1:0]        total_count;
	logic [FRAC_W-1:0]         fraction;
	logic [LEN_W-1:0]          table_length_reg;
	result_t                   expected_q [$];
	result_t                   got_word;
	result_t                   want_word;
	int                        error_count = 0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t checker: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
		error_count++;
	endtask

	function automatic result_t rank_query(input logic signed [SCORE_W-1:0] q);
		int unsigned               len;
		int unsigned               i;
		logic                      desc;
		logic signed [SCORE_W-1:0] last;
		logic [63:0]               num;
		logic [63:0]               den;
		logic [63:0]               quo;
		result_t                   r;
		len = table_length_reg;
		if (len < LENGTH_MIN) len = LENGTH_MIN;
		if (len > LENGTH_MAX) len = LENGTH_MAX;
		desc = scores[0] > scores[1];
		last = scores[len - 1];
		r.beyond = desc ? (q < last) : (q > last);
		if (r.beyond) begin
			i = len;
			r.p_value = ONE_Q16;
			r.significant = 1'b0;
		end else begin
			// walk to the first entry the query passes
			i = 0;
			while (i < len && !(desc ? (q > scores[i]) : (q < scores[i])))
				i++;
			num = 64'(i + 1) << 32;
			den = 64'(total_count) * 64'(fraction);
			if (den == 0) begin
				r.p_value = ONE_Q16;
				r.significant = 1'b0;
			end else begin
				quo = num / den;
				r.significant = num < (den << 16);
				r.p_value = (quo > 64'(ONE_Q16)) ? ONE_Q16 : quo[P_W-1:0];
			end
		end
		r.rank = LEN_W'(i + 1);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_count = TOTAL_RESET;
			fraction = FRACTION_RESET;
			table_length_reg = LENGTH_RESET;
			expected_q.delete();
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr)
						{REG_TOTAL, 2'b00}:    total_count = pwdata[TOTAL_W-1:0];
						{REG_FRACTION, 2'b00}: fraction = pwdata[FRAC_W-1:0];
						{REG_LENGTH, 2'b00}:   table_length_reg = pwdata[LEN_W-1:0];
						default: ;
					endcase
				end else begin
					case (paddr)
						{REG_TOTAL, 2'b00}:
							if (prdata !== 32'(total_count))
								report_mismatch("total_count readback", prdata, 32'(total_count));
						{REG_FRACTION, 2'b00}:
							if (prdata !== 32'(fraction))
								report_mismatch("fraction_q16 readback", prdata, 32'(fraction));
						{REG_LENGTH, 2'b00}:
							if (prdata !== 32'(table_length_reg))
								report_mismatch("table_length readback", prdata,
									32'(table_length_reg));
						default: ;
					endcase
				end
			end
			if (m_tvalid && m_tready) begin
				got_word.p_value = m_tdata[16:0];
				got_word.rank = m_tdata[29:17];
				got_word.beyond = m_tdata[30];
				got_word.significant = m_tdata[31];
				if (expected_q.size() == 0) begin
					report_mismatch("result word with no query waiting", m_tdata, 32'd0);
				end else begin
					want_word = expected_q.pop_front();
					if (got_word.p_value !== want_word.p_value)
						report_mismatch("p_value_q16", 32'(got_word.p_value),
							32'(want_word.p_value));
					if (got_word.rank !== want_word.rank)
						report_mismatch("rank_position", 32'(got_word.rank), 32'(want_word.rank));
					if (got_word.beyond !== want_word.beyond)
						report_mismatch("beyond_table", 32'(got_word.beyond),
							32'(want_word.beyond));
					if (got_word.significant !== want_word.significant)
						report_mismatch("significant", 32'(got_word.significant),
							32'(want_word.significant));
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == CMD_LOAD)
					scores[s_tdata[ADDR_W-1:0]] = s_tdata[ADDR_W+SCORE_W-1:ADDR_W];
				else
					expected_q.insert(expected_q.size(),
						rank_query(s_tdata[ADDR_W+SCORE_W-1:ADDR_W]));
			end
		end
		pending <= expected_q.size();
		fails <= error_count;
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// top of the p-value lookup testbench: clock, reset, stimulus, watchdog and verdict
module tb_top;
	import epvl_pkg::*;

	localparam int RANDOM_ITEMS   = 1520;
	localparam int HEAD_ENTRIES   = 64;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 64;
	localparam int WATCHDOG_LIMIT = 20000;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // entry_index[11:0], score_value[43:12], zero pad
	logic [0:0]  s_tuser;   // command
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // p_value_q16[16:0], rank_position[29:17],
	                        // beyond_table[30], significant[31]
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int pending;
	int fails;

	bit tx_quiet;
	bit rx_quiet;
	bit hold_request;
	int items_sent;
	int table_len;
	int written_upto;
	logic signed [SCORE_W-1:0] loaded [TABLE_DEPTH];

	empirical_p_value_lookup_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	epvl_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.pending  (pending),
		.fails    (fails)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_word(input logic cmd, input logic [ADDR_W-1:0] idx,
			input logic [SCORE_W-1:0] score);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {4'b0, score, idx};
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic load_entry(input logic [ADDR_W-1:0] idx, input logic [SCORE_W-1:0] score);
		send_word(CMD_LOAD, idx, score);
		loaded[idx] = score;
	endtask

	task automatic query(input logic [SCORE_W-1:0] score);
		send_word(CMD_QUERY, ADDR_W'($urandom_range(0, TABLE_DEPTH - 1)), score);
	endtask

	// wait until every query has its result and the block is idle
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic read_reg(input logic [1:0] index);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {index, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic apb_idle();
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic configure(input logic [TOTAL_W-1:0] total, input logic [FRAC_W-1:0] frac,
			input logic [LEN_W-1:0] len);
		settle();
		write_reg(REG_TOTAL, 32'(total));
		write_reg(REG_FRACTION, 32'(frac));
		write_reg(REG_LENGTH, 32'(len));
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_UNUSED, $urandom);
		read_reg(REG_TOTAL);
		read_reg(REG_FRACTION);
		read_reg(REG_LENGTH);
		apb_idle();
		if (len < LENGTH_MIN)
			table_len = LENGTH_MIN;
		else if (len > LENGTH_MAX)
			table_len = LENGTH_MAX;
		else
			table_len = len;
	endtask

	// monotone table with random spacing, ties and saturation at the score extremes
	task automatic load_sorted(input int n, input bit descending);
		longint      v;
		int unsigned step_max;
		int          k;
		case ($urandom_range(0, 2))
			0:       step_max = 3;
			1:       step_max = 5000;
			default: step_max = 32'hFFFF_FFFF / n;
		endcase
		if (step_max > 5000 && $urandom_range(0, 1))
			v = descending ? SCORE_MAX : SCORE_MIN;
		else
			v = longint'($signed($urandom));
		for (k = 0; k < n; k++) begin
			load_entry(ADDR_W'(k), v[SCORE_W-1:0]);
			if (descending)
				v = v - longint'($urandom_range(0, step_max));
			else
				v = v + longint'($urandom_range(0, step_max));
			if (v > longint'(SCORE_MAX)) v = SCORE_MAX;
			if (v < longint'(SCORE_MIN)) v = SCORE_MIN;
		end
		if (n > written_upto)
			written_upto = n;
	endtask

	function automatic logic [SCORE_W-1:0] pick_query();
		int                        k;
		logic signed [SCORE_W-1:0] e;
		logic signed [SCORE_W-1:0] last;
		k = $urandom_range(0, table_len - 1);
		e = loaded[k];
		last = loaded[table_len - 1];
		case ($urandom_range(0, 9))
			0:       return $urandom;
			1:       return last;
			2:       return last + 1;
			3:       return last - 1;
			4:       return e + 1;
			5:       return e - 1;
			6:       return $urandom_range(0, 1) ? SCORE_MAX : SCORE_MIN;
			default: return e;
		endcase
	endfunction

	// receiver: random stalls per word, one long hold-off on request
	initial begin : receiver
		int gap;
		m_tready = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (hold_request) begin
				gap = HOLD_CYCLES;
				hold_request = 1'b0;
			end else begin
				gap = rx_quiet ? 0 : $urandom_range(0, 7);
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin : stimulus
		int                 phase;
		int                 n_q;
		int                 k;
		int                 random_end;
		logic [TOTAL_W-1:0] tot;
		logic [FRAC_W-1:0]  frac;
		logic [LEN_W-1:0]   len;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		hold_request = 1'b0;
		items_sent = 0;
		written_upto = 0;
		table_len = LENGTH_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values read back
		read_reg(REG_TOTAL);
		read_reg(REG_FRACTION);
		read_reg(REG_LENGTH);
		apb_idle();

		// directed: length below the minimum, descending extremes
		configure(TOTAL_RESET, FRACTION_RESET, '0);
		load_entry(0, SCORE_MAX);
		load_entry(1, SCORE_MIN);
		written_upto = 2;
		query(SCORE_MAX);
		query(SCORE_MIN);
		query('0);
		// equal first entries make the table ascending
		load_entry(1, SCORE_MAX);
		query(SCORE_MIN);
		query(SCORE_MAX);
		configure(TOTAL_W'(100), FRACTION_RESET, LEN_W'(3));
		load_entry(0, -32'sd5);
		load_entry(1, 32'sd0);
		load_entry(2, 32'sd7);
		written_upto = 3;
		query(32'sd8);
		query(32'sd7);
		query(-32'sd6);
		query(32'sd0);
		query(32'sd3);
		load_entry(ADDR_W'(TABLE_DEPTH - 1), $urandom);
		configure('0, FRACTION_RESET, LEN_W'(3));
		query(32'sd0);
		configure(TOTAL_W'(100), '0, LEN_W'(3));
		query(32'sd0);
		configure('1, '1, LEN_W'(3));
		query(-32'sd6);
		configure('1, FRAC_W'(1), LEN_W'(1));
		query(32'sd3);

		// random phases: sorted tables with random queries, some noise loads
		phase = 0;
		random_end = items_sent + RANDOM_ITEMS;
		while (items_sent < random_end) begin
			case ($urandom_range(0, 15))
				0:                   tot = '0;
				1, 2:                tot = TOTAL_W'($urandom_range(1, 8));
				3, 4, 5, 6, 7, 8:    tot = TOTAL_W'($urandom_range(1, 300));
				9, 10, 11:           tot = TOTAL_W'($urandom_range(1, 16777215));
				12:                  tot = '1;
				default:             tot = TOTAL_RESET;
			endcase
			case ($urandom_range(0, 15))
				0:                   frac = '0;
				1:                   frac = '1;
				2:                   frac = FRAC_W'(1);
				3, 4, 5, 6:          frac = FRAC_W'($urandom_range(1, 131071));
				default:             frac = FRACTION_RESET;
			endcase
			case ($urandom_range(0, 15))
				0:                   len = LEN_W'($urandom_range(0, 1));
				11, 12, 13:          len = LEN_W'($urandom_range(17, 64));
				14, 15:              len = LEN_W'($urandom_range(65, 300));
				default:             len = LEN_W'($urandom_range(2, 16));
			endcase
			configure(tot, frac, len);
			tx_quiet = ($urandom_range(0, 4) == 0);
			rx_quiet = ($urandom_range(0, 4) == 0);
			if (table_len > written_upto || $urandom_range(0, 3) != 0)
				load_sorted(table_len, $urandom_range(0, 1));
			if (phase == 4) begin
				// long receiver hold-off while queries keep coming
				tx_quiet = 1'b1;
				hold_request = 1'b1;
			end
			n_q = $urandom_range(8, 30);
			for (k = 0; k < n_q; k++) begin
				if ($urandom_range(0, 7) == 0)
					load_entry(ADDR_W'($urandom_range(0, TABLE_DEPTH - 1)), $urandom);
				else
					query(pick_query());
			end
			phase++;
		end

		// full-depth length, above the maximum and at the maximum: a descending head
		// and the last entry are loaded, queries stop within the head or lie beyond
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		configure('1, FRACTION_RESET, '1);
		for (k = 0; k < HEAD_ENTRIES; k++)
			load_entry(ADDR_W'(k), SCORE_W'(1000 - 16 * k));
		load_entry(ADDR_W'(TABLE_DEPTH - 1), -32'sd100000);
		query(-32'sd100001);
		query(SCORE_MIN);
		query(32'sd1001);
		query(32'sd1000);
		query(SCORE_MAX);
		query(-32'sd7);
		configure(TOTAL_W'(1000), FRACTION_RESET, LENGTH_MAX);
		query(32'sd500);
		query(SCORE_MIN);
		query(32'sd0);

		settle();
		if (fails == 0 && pending == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

// File: empirical_p_value_lookup_core.f
+incdir+rtl
rtl/epvl_pkg.sv
rtl/empirical_p_value_lookup_core.sv
tb/epvl_checker.sv
tb/tb_top.sv
